/* sv/lookat_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and cross-product helpers for the look-at basis pipeline.
// No dependencies; every other file imports this package.
package lookat_pkg;

  // Fixed point formats
  localparam int IN_FRAC_BITS = 16;
  localparam int MIN_LEN_W    = 17;
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 17'd66;
  localparam int MINSQ_W      = 2 * MIN_LEN_W;

  // Normalizer widths
  localparam int MAG_W    = 63;  // magnitude of a cross product component
  localparam int NRM_W    = 31;  // magnitude after scaling into [2^30, 2^31)
  localparam int RAD_W    = 64;  // sum of three squares
  localparam int ROOT_W   = 32;  // floor square root of that sum
  localparam int NUM_W    = 62;  // dividend of the unit-vector division
  localparam int SQ_STEPS = 32;  // one root bit per stage
  localparam int DV_STEPS = 31;  // one quotient bit per stage
  localparam int UNIT_SH  = 30;  // Q1.30

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NULL      = 2'd1,
    ST_COLLINEAR = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_MIN_LENGTH = 1'd0
  } reg_idx_t;

  typedef logic [2:0][31:0] v32_t;
  typedef logic [2:0][63:0] v64_t;
  typedef logic [5:0][63:0] prod_t;

  typedef struct packed {
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
    logic signed [31:0] to_z;
    logic               from_valid;
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] from_z;
    logic               hint_valid;
    logic signed [31:0] hint_x;
    logic signed [31:0] hint_y;
    logic signed [31:0] hint_z;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] side_x;
    logic signed [31:0] side_y;
    logic signed [31:0] side_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
    logic signed [31:0] fwd_x;
    logic signed [31:0] fwd_y;
    logic signed [31:0] fwd_z;
  } out_t;

  // Per-item context that rides along the whole pipeline
  typedef struct packed {
    status_t status;
    logic    hint_valid;
    v32_t    hint;
    v32_t    f;
    v32_t    s;
  } tag_t;

  typedef struct packed {
    tag_t                  tag;
    logic [2:0][NRM_W-1:0] mn;
    logic [2:0]            neg;
    logic                  zero;
  } sq_tag_t;

  typedef struct packed {
    tag_t       tag;
    logic [2:0] neg;
    logic       zero;
  } dv_tag_t;

  // Six partial products of a x b: a1b2, a2b1, a2b0, a0b2, a0b1, a1b0
  function automatic prod_t cross_prod(v32_t a, v32_t b);
    prod_t p;
    p[0] = $signed(a[1]) * $signed(b[2]);
    p[1] = $signed(a[2]) * $signed(b[1]);
    p[2] = $signed(a[2]) * $signed(b[0]);
    p[3] = $signed(a[0]) * $signed(b[2]);
    p[4] = $signed(a[0]) * $signed(b[1]);
    p[5] = $signed(a[1]) * $signed(b[0]);
    return p;
  endfunction

  function automatic v64_t cross_diff(prod_t p);
    v64_t c;
    c[0] = p[0] - p[1];
    c[1] = p[2] - p[3];
    c[2] = p[4] - p[5];
    return c;
  endfunction

endpackage

/* sv/look_at_orthonormal_basis_top.sv */
`timescale 1ns / 1ps
// Top level of the look-at basis pipeline: forward setup, three normalizers,
// side selection, up cross product, output register with skid. Depends on all sv/ files.
//
//   channel | ports                               | moves
//   --------+-------------------------------------+----------------------------------
//   input   | in_valid, in_stall, in_data         | one item: target, origin, up hint
//   output  | out_valid, out_stall, out_data      | one item: status and three axes
//   config  | cfg_psel/penable/pwrite/paddr/...   | min_length at byte address 0
//
// One item enters per cycle while in_stall is low. Pipeline stages: 3 forward setup, 71 in each of
// three normalizers (32 square-root and 31 divide stages among them), 6 side select,
// 2 up cross product and 1 output register.
// Reset clears all valid bits and sets min_length to 66.
// A result waiting at the output does not stop the pipeline until the skid stage
// also holds one; then in_stall rises and every stage holds.
module look_at_orthonormal_basis_top
  import lookat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic en;
  logic skid_vld_r;

  // Configuration register
  logic [MIN_LEN_W-1:0] min_length_r;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (reg_idx_t'(cfg_paddr[2]) == REG_MIN_LENGTH);
  assign cfg_prdata = (reg_idx_t'(cfg_paddr[2]) == REG_MIN_LENGTH) ?
                      32'(min_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= MIN_LEN_RST;
    end else if (cfg_wr) begin
      min_length_r <= cfg_pwdata[MIN_LEN_W-1:0];
    end
  end

  // Hold the whole pipeline only while the skid stage is full
  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  // Stage F1: forward vector with saturated differences
  v32_t to_v, from_v, hint_v, f1_fw_nxt;
  logic f1_vld_r;
  v32_t f1_fw_r;
  tag_t f1_tag_r, f1_tag_nxt;

  assign to_v   = {in_data.to_z, in_data.to_y, in_data.to_x};
  assign from_v = {in_data.from_z, in_data.from_y, in_data.from_x};
  assign hint_v = {in_data.hint_z, in_data.hint_y, in_data.hint_x};

  always_comb begin
    logic [32:0] d;
    for (int j = 0; j < 3; j++) begin
      d = {to_v[j][31], to_v[j]};
      if (in_data.from_valid) d = d - {from_v[j][31], from_v[j]};
      if (d[32] != d[31]) begin
        f1_fw_nxt[j] = d[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        f1_fw_nxt[j] = d[31:0];
      end
    end
    f1_tag_nxt            = '0;
    f1_tag_nxt.status     = ST_OK;
    f1_tag_nxt.hint_valid = in_data.hint_valid;
    f1_tag_nxt.hint       = hint_v;
  end

  // Stage F2: squared forward length
  logic f2_vld_r;
  v32_t f2_fw_r;
  logic [2:0][63:0] f2_sq_r, f2_sq_nxt;
  logic [MINSQ_W-1:0] f2_minsq_r, f2_minsq_nxt;
  logic f2_zero_r;
  tag_t f2_tag_r;

  always_comb begin
    logic [31:0] m;
    for (int j = 0; j < 3; j++) begin
      m = f1_fw_r[j][31] ? 32'd0 - f1_fw_r[j] : f1_fw_r[j];
      f2_sq_nxt[j] = 64'(m) * 64'(m);
    end
    f2_minsq_nxt = MINSQ_W'(min_length_r) * MINSQ_W'(min_length_r);
  end

  // Stage F3: null forward check
  logic f3_vld_r;
  v64_t f3_fw_r, f3_fw_nxt;
  tag_t f3_tag_r, f3_tag_nxt;

  always_comb begin
    logic [63:0] sum;
    sum        = f2_sq_r[0] + f2_sq_r[1] + f2_sq_r[2];
    f3_tag_nxt = f2_tag_r;
    if (f2_zero_r || sum < 64'(f2_minsq_r)) f3_tag_nxt.status = ST_NULL;
    for (int j = 0; j < 3; j++) begin
      f3_fw_nxt[j] = {{32{f2_fw_r[j][31]}}, f2_fw_r[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= in_valid;
      f2_vld_r <= f1_vld_r;
      f3_vld_r <= f2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_fw_r    <= f1_fw_nxt;
      f1_tag_r   <= f1_tag_nxt;
      f2_fw_r    <= f1_fw_r;
      f2_sq_r    <= f2_sq_nxt;
      f2_minsq_r <= f2_minsq_nxt;
      f2_zero_r  <= (f1_fw_r == '0);
      f2_tag_r   <= f1_tag_r;
      f3_fw_r    <= f3_fw_nxt;
      f3_tag_r   <= f3_tag_nxt;
    end
  end

  // Normalize forward
  logic na_vld;
  v32_t na_v;
  tag_t na_tag;

  lookat_unit u_norm_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (f3_vld_r),
    .in_v    (f3_fw_r),
    .in_tag  (f3_tag_r),
    .out_vld (na_vld),
    .out_v   (na_v),
    .out_tag (na_tag)
  );

  // Build and pick the side vector
  logic sd_vld;
  v64_t sd_c;
  tag_t sd_tag;

  lookat_side u_side (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .min_length (min_length_r),
    .in_vld     (na_vld),
    .in_f       (na_v),
    .in_tag     (na_tag),
    .out_vld    (sd_vld),
    .out_c      (sd_c),
    .out_tag    (sd_tag)
  );

  // Normalize side
  logic nb_vld;
  v32_t nb_v;
  tag_t nb_tag;

  lookat_unit u_norm_side (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sd_vld),
    .in_v    (sd_c),
    .in_tag  (sd_tag),
    .out_vld (nb_vld),
    .out_v   (nb_v),
    .out_tag (nb_tag)
  );

  // Stages C1 and C2: up = forward x side
  logic  c1_vld_r, c2_vld_r;
  prod_t c1_p_r;
  tag_t  c1_tag_r, c1_tag_nxt, c2_tag_r;
  v64_t  c2_c_r;

  always_comb begin
    c1_tag_nxt   = nb_tag;
    c1_tag_nxt.s = nb_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
      c2_vld_r <= 1'b0;
    end else if (en) begin
      c1_vld_r <= nb_vld;
      c2_vld_r <= c1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_p_r   <= cross_prod(nb_tag.f, nb_v);
      c1_tag_r <= c1_tag_nxt;
      c2_c_r   <= cross_diff(c1_p_r);
      c2_tag_r <= c1_tag_r;
    end
  end

  // Normalize up
  logic nc_vld;
  v32_t nc_v;
  tag_t nc_tag;

  lookat_unit u_norm_up (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (c2_vld_r),
    .in_v    (c2_c_r),
    .in_tag  (c2_tag_r),
    .out_vld (nc_vld),
    .out_v   (nc_v),
    .out_tag (nc_tag)
  );

  // Assemble the result item, zero axes on failure
  out_t res;

  always_comb begin
    res        = '0;
    res.status = nc_tag.status;
    if (nc_tag.status == ST_OK) begin
      res.side_x = nc_tag.s[0];
      res.side_y = nc_tag.s[1];
      res.side_z = nc_tag.s[2];
      res.up_x   = nc_v[0];
      res.up_y   = nc_v[1];
      res.up_z   = nc_v[2];
      res.fwd_x  = nc_tag.f[0];
      res.fwd_y  = nc_tag.f[1];
      res.fwd_z  = nc_tag.f[2];
    end
  end

  // Output register and skid stage
  logic out_vld_r, out_vld_nxt, skid_vld_nxt, take;
  logic load_out, load_skid, out_from_skid;
  out_t out_data_r, skid_data_r;

  assign take = out_vld_r && !out_stall;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    skid_vld_nxt  = skid_vld_r;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_vld_r) begin
      if (take) begin
        out_from_skid = 1'b1;
        skid_vld_nxt  = 1'b0;
      end
    end else if (nc_vld) begin
      if (!out_vld_r || take) begin
        load_out    = 1'b1;
        out_vld_nxt = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_vld_nxt = 1'b1;
      end
    end else if (take) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_from_skid) begin
      out_data_r <= skid_data_r;
    end else if (load_out) begin
      out_data_r <= res;
    end
    if (load_skid) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // The skid stage only fills behind a waiting output item
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid stage full while output register is empty");

  // A failed item carries all-zero axes; checked on fwd_x, side_y and up_z
  a_fail_zero_axes: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.status != ST_OK |->
      out_data_r.fwd_x == 0 && out_data_r.side_y == 0 && out_data_r.up_z == 0)
    else $error("failed item with nonzero axes");

  // Forward and side x components stay within one in Q1.30
  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.status == ST_OK |->
      out_data_r.fwd_x <= 32'sh4000_0000 && out_data_r.fwd_x >= -32'sh4000_0000 &&
      out_data_r.side_x <= 32'sh4000_0000 && out_data_r.side_x >= -32'sh4000_0000)
    else $error("axis component beyond unit range");

  // A held pipeline keeps its result item
  a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && out_stall |=> skid_vld_r && $stable(skid_data_r))
    else $error("skid item lost while output stalled");

endmodule

/* sv/lookat_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined floor square root of a 64-bit radicand, one root bit per stage.
// Depends on lookat_pkg; carries the normalizer context alongside.
module lookat_sqrt
  import lookat_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [RAD_W-1:0] in_rad,
  input  sq_tag_t          in_tag,
  output logic             out_vld,
  output logic [ROOT_W-1:0] out_root,
  output sq_tag_t          out_tag
);

  logic [SQ_STEPS-1:0] vld_r;
  logic [RAD_W-1:0]    rem_r   [SQ_STEPS];
  logic [RAD_W-1:0]    rem_nxt [SQ_STEPS];
  logic [RAD_W-1:0]    rt_r    [SQ_STEPS];
  logic [RAD_W-1:0]    rt_nxt  [SQ_STEPS];
  sq_tag_t             tag_r   [SQ_STEPS];

  // Try one root bit per stage, highest first
  always_comb begin
    logic [RAD_W-1:0] rem_p;
    logic [RAD_W-1:0] rt_p;
    logic [RAD_W-1:0] bit_c;
    logic [RAD_W:0]   trial;
    for (int i = 0; i < SQ_STEPS; i++) begin
      rem_p = (i == 0) ? in_rad : rem_r[(i == 0) ? 0 : i-1];
      rt_p  = (i == 0) ? '0     : rt_r[(i == 0) ? 0 : i-1];
      bit_c = RAD_W'(1) << (2 * (SQ_STEPS - 1 - i));
      trial = {1'b0, rt_p} + {1'b0, bit_c};
      if ({1'b0, rem_p} >= trial) begin
        rem_nxt[i] = rem_p - trial[RAD_W-1:0];
        rt_nxt[i]  = (rt_p >> 1) + bit_c;
      end else begin
        rem_nxt[i] = rem_p;
        rt_nxt[i]  = rt_p >> 1;
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQ_STEPS-2:0], in_vld};
    end
  end

  // Advance data
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQ_STEPS; i++) begin
        rem_r[i] <= rem_nxt[i];
        rt_r[i]  <= rt_nxt[i];
        tag_r[i] <= (i == 0) ? in_tag : tag_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign out_vld  = vld_r[SQ_STEPS-1];
  assign out_root = rt_r[SQ_STEPS-1][ROOT_W-1:0];
  assign out_tag  = tag_r[SQ_STEPS-1];

endmodule

/* sv/lookat_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit a stage.
// Depends on lookat_pkg; carries sign and zero flags alongside.
module lookat_div
  import lookat_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [2:0][NUM_W-1:0]      in_num,
  input  logic [ROOT_W-1:0]          in_den,
  input  dv_tag_t                    in_tag,
  output logic                       out_vld,
  output logic [2:0][DV_STEPS-1:0]   out_quo,
  output dv_tag_t                    out_tag
);

  logic [DV_STEPS-1:0]          vld_r;
  logic [2:0][NUM_W-1:0]        rem_r   [DV_STEPS];
  logic [2:0][NUM_W-1:0]        rem_nxt [DV_STEPS];
  logic [2:0][DV_STEPS-1:0]     quo_r   [DV_STEPS];
  logic [2:0][DV_STEPS-1:0]     quo_nxt [DV_STEPS];
  logic [ROOT_W-1:0]            den_r   [DV_STEPS];
  dv_tag_t                      tag_r   [DV_STEPS];

  // Subtract the shifted divisor where it fits
  always_comb begin
    logic [2:0][NUM_W-1:0]    rem_p;
    logic [2:0][DV_STEPS-1:0] quo_p;
    logic [ROOT_W-1:0]        den_p;
    logic [NUM_W:0]           dsh;
    for (int i = 0; i < DV_STEPS; i++) begin
      rem_p = (i == 0) ? in_num : rem_r[(i == 0) ? 0 : i-1];
      quo_p = (i == 0) ? '0     : quo_r[(i == 0) ? 0 : i-1];
      den_p = (i == 0) ? in_den : den_r[(i == 0) ? 0 : i-1];
      dsh   = (NUM_W+1)'(den_p) << (DV_STEPS - 1 - i);
      for (int j = 0; j < 3; j++) begin
        if ({1'b0, rem_p[j]} >= dsh) begin
          rem_nxt[i][j] = rem_p[j] - dsh[NUM_W-1:0];
          quo_nxt[i][j] = {quo_p[j][DV_STEPS-2:0], 1'b1};
        end else begin
          rem_nxt[i][j] = rem_p[j];
          quo_nxt[i][j] = {quo_p[j][DV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DV_STEPS-2:0], in_vld};
    end
  end

  // Advance data
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DV_STEPS; i++) begin
        rem_r[i] <= rem_nxt[i];
        quo_r[i] <= quo_nxt[i];
        den_r[i] <= (i == 0) ? in_den : den_r[(i == 0) ? 0 : i-1];
        tag_r[i] <= (i == 0) ? in_tag : tag_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign out_vld = vld_r[DV_STEPS-1];
  assign out_quo = quo_r[DV_STEPS-1];
  assign out_tag = tag_r[DV_STEPS-1];

endmodule

/* sv/lookat_unit.sv */
`timescale 1ns / 1ps
// Vector normalizer: scale, sum of squares, square root and divide into Q1.30 axes.
// Depends on lookat_pkg, lookat_sqrt and lookat_div.
module lookat_unit
  import lookat_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  v64_t in_v,
  input  tag_t in_tag,
  output logic out_vld,
  output v32_t out_v,
  output tag_t out_tag
);

  // Stage a: magnitudes and largest magnitude
  logic                  a_vld_r;
  logic [2:0][MAG_W-1:0] a_mag_r, a_mag_nxt;
  logic [2:0]            a_neg_r, a_neg_nxt;
  logic [MAG_W-1:0]      a_mx_r, a_mx_nxt;
  tag_t                  a_tag_r;

  always_comb begin
    a_mx_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      a_neg_nxt[j] = in_v[j][63];
      a_mag_nxt[j] = in_v[j][63] ? MAG_W'(64'd0 - in_v[j]) : in_v[j][MAG_W-1:0];
      if (a_mag_nxt[j] > a_mx_nxt) a_mx_nxt = a_mag_nxt[j];
    end
  end

  // Stage b: leading one inside each byte of the largest magnitude
  logic                  b_vld_r;
  logic [2:0][MAG_W-1:0] b_mag_r;
  logic [2:0]            b_neg_r;
  logic [7:0]            b_nz_r, b_nz_nxt;
  logic [7:0][2:0]       b_pos_r, b_pos_nxt;
  tag_t                  b_tag_r;

  always_comb begin
    logic [63:0] word;
    word = {1'b0, a_mx_r};
    for (int g = 0; g < 8; g++) begin
      b_nz_nxt[g]  = |word[g*8 +: 8];
      b_pos_nxt[g] = '0;
      for (int k = 0; k < 8; k++) begin
        if (word[g*8 + k]) b_pos_nxt[g] = 3'(k);
      end
    end
  end

  // Stage c: pick the top byte
  logic                  c_vld_r;
  logic [2:0][MAG_W-1:0] c_mag_r;
  logic [2:0]            c_neg_r;
  logic [5:0]            c_pos_r, c_pos_nxt;
  logic                  c_zero_r, c_zero_nxt;
  tag_t                  c_tag_r;

  always_comb begin
    c_pos_nxt  = '0;
    c_zero_nxt = 1'b1;
    for (int g = 0; g < 8; g++) begin
      if (b_nz_r[g]) begin
        c_pos_nxt  = {3'(g), b_pos_r[g]};
        c_zero_nxt = 1'b0;
      end
    end
  end

  // Stage d: shift so that the largest magnitude lands in [2^30, 2^31)
  logic                  d_vld_r;
  logic [2:0][NRM_W-1:0] d_mn_r, d_mn_nxt;
  logic [2:0]            d_neg_r;
  logic                  d_zero_r;
  tag_t                  d_tag_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (c_pos_r >= 6'(UNIT_SH)) begin
        d_mn_nxt[j] = NRM_W'(c_mag_r[j] >> (c_pos_r - 6'(UNIT_SH)));
      end else begin
        d_mn_nxt[j] = NRM_W'(c_mag_r[j] << (6'(UNIT_SH) - c_pos_r));
      end
    end
  end

  // Stage e: squares
  logic                      e_vld_r;
  logic [2:0][2*NRM_W-1:0]   e_sq_r, e_sq_nxt;
  logic [2:0][NRM_W-1:0]     e_mn_r;
  logic [2:0]                e_neg_r;
  logic                      e_zero_r;
  tag_t                      e_tag_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      e_sq_nxt[j] = (2*NRM_W)'(d_mn_r[j]) * (2*NRM_W)'(d_mn_r[j]);
    end
  end

  // Stage f: sum of squares
  logic             f_vld_r;
  logic [RAD_W-1:0] f_rad_r, f_rad_nxt;
  sq_tag_t          f_tag_r;

  assign f_rad_nxt = RAD_W'(e_sq_r[0]) + RAD_W'(e_sq_r[1]) + RAD_W'(e_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag_r       <= a_mag_nxt;
      a_neg_r       <= a_neg_nxt;
      a_mx_r        <= a_mx_nxt;
      a_tag_r       <= in_tag;
      b_mag_r       <= a_mag_r;
      b_neg_r       <= a_neg_r;
      b_nz_r        <= b_nz_nxt;
      b_pos_r       <= b_pos_nxt;
      b_tag_r       <= a_tag_r;
      c_mag_r       <= b_mag_r;
      c_neg_r       <= b_neg_r;
      c_pos_r       <= c_pos_nxt;
      c_zero_r      <= c_zero_nxt;
      c_tag_r       <= b_tag_r;
      d_mn_r        <= d_mn_nxt;
      d_neg_r       <= c_neg_r;
      d_zero_r      <= c_zero_r;
      d_tag_r       <= c_tag_r;
      e_sq_r        <= e_sq_nxt;
      e_mn_r        <= d_mn_r;
      e_neg_r       <= d_neg_r;
      e_zero_r      <= d_zero_r;
      e_tag_r       <= d_tag_r;
      f_rad_r       <= f_rad_nxt;
      f_tag_r.tag   <= e_tag_r;
      f_tag_r.mn    <= e_mn_r;
      f_tag_r.neg   <= e_neg_r;
      f_tag_r.zero  <= e_zero_r;
    end
  end

  // Square root of the sum
  logic              s_vld;
  logic [ROOT_W-1:0] s_root;
  sq_tag_t           s_tag;

  lookat_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld_r),
    .in_rad   (f_rad_r),
    .in_tag   (f_tag_r),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_tag  (s_tag)
  );

  // Stage g: dividends with half the length added for rounding
  logic                  g_vld_r;
  logic [2:0][NUM_W-1:0] g_num_r, g_num_nxt;
  logic [ROOT_W-1:0]     g_den_r;
  dv_tag_t               g_tag_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      g_num_nxt[j] = NUM_W'({s_tag.mn[j], UNIT_SH'(0)}) + NUM_W'(s_root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_num_r      <= g_num_nxt;
      g_den_r      <= s_root;
      g_tag_r.tag  <= s_tag.tag;
      g_tag_r.neg  <= s_tag.neg;
      g_tag_r.zero <= s_tag.zero;
    end
  end

  // Divide each magnitude by the length
  logic                     q_vld;
  logic [2:0][DV_STEPS-1:0] q_quo;
  dv_tag_t                  q_tag;

  lookat_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (g_vld_r),
    .in_num  (g_num_r),
    .in_den  (g_den_r),
    .in_tag  (g_tag_r),
    .out_vld (q_vld),
    .out_quo (q_quo),
    .out_tag (q_tag)
  );

  // Stage h: restore signs, force zero for a zero vector
  logic h_vld_r;
  v32_t h_v_r, h_v_nxt;
  tag_t h_tag_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (q_tag.zero) begin
        h_v_nxt[j] = '0;
      end else if (q_tag.neg[j]) begin
        h_v_nxt[j] = 32'd0 - 32'(q_quo[j]);
      end else begin
        h_v_nxt[j] = 32'(q_quo[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_v_r   <= h_v_nxt;
      h_tag_r <= q_tag.tag;
    end
  end

  assign out_vld = h_vld_r;
  assign out_v   = h_v_r;
  assign out_tag = h_tag_r;

endmodule

/* sv/lookat_side.sv */
`timescale 1ns / 1ps
// Side-axis candidate builder: hint, world up and world forward crossed with forward,
// length checks against min_length and selection. Depends on lookat_pkg.
module lookat_side
  import lookat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [MIN_LEN_W-1:0] min_length,
  input  logic                 in_vld,
  input  v32_t                 in_f,
  input  tag_t                 in_tag,
  output logic                 out_vld,
  output v64_t                 out_c,
  output tag_t                 out_tag
);

  localparam int T_W = 34;

  // Stage 1: hint products and world candidates
  logic s1_vld_r;
  prod_t s1_p_r;
  v64_t s1_cu_r, s1_cu_nxt, s1_cf_r, s1_cf_nxt;
  tag_t s1_tag_r, s1_tag_nxt;

  always_comb begin
    logic [63:0] f0s, f1s, f2s;
    f0s = {{(32-IN_FRAC_BITS){in_f[0][31]}}, in_f[0], IN_FRAC_BITS'(0)};
    f1s = {{(32-IN_FRAC_BITS){in_f[1][31]}}, in_f[1], IN_FRAC_BITS'(0)};
    f2s = {{(32-IN_FRAC_BITS){in_f[2][31]}}, in_f[2], IN_FRAC_BITS'(0)};
    s1_cu_nxt[0] = f2s;
    s1_cu_nxt[1] = '0;
    s1_cu_nxt[2] = 64'd0 - f0s;
    s1_cf_nxt[0] = 64'd0 - f1s;
    s1_cf_nxt[1] = f0s;
    s1_cf_nxt[2] = '0;
    s1_tag_nxt   = in_tag;
    s1_tag_nxt.f = in_f;
  end

  // Stage 2: hint cross product
  logic s2_vld_r;
  logic [2:0][2:0][63:0] s2_cand_r;  // hint, world up, world forward
  tag_t s2_tag_r;

  // Stage 3: truncate toward zero to input format
  logic s3_vld_r;
  logic [2:0][2:0][63:0]  s3_cand_r;
  logic [2:0][2:0][T_W-1:0] s3_mag_r, s3_mag_nxt;
  logic [2:0] s3_zero_r, s3_zero_nxt;
  tag_t s3_tag_r;

  always_comb begin
    logic [63:0] x;
    logic [63:0] tr;
    logic [T_W-1:0] ts;
    for (int c = 0; c < 3; c++) begin
      s3_zero_nxt[c] = (s2_cand_r[c] == '0);
      for (int j = 0; j < 3; j++) begin
        x = s2_cand_r[c][j];
        if (x[63]) x = x + ((64'd1 << UNIT_SH) - 64'd1);
        tr = $signed(x) >>> UNIT_SH;
        ts = tr[T_W-1:0];
        s3_mag_nxt[c][j] = ts[T_W-1] ? T_W'(0) - ts : ts;
      end
    end
  end

  // Stage 4: squares, kept modulo 2^64
  logic s4_vld_r;
  logic [2:0][2:0][63:0] s4_cand_r, s4_sq_r, s4_sq_nxt;
  logic [2:0] s4_zero_r;
  tag_t s4_tag_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 3; j++) begin
        s4_sq_nxt[c][j] = 64'(s3_mag_r[c][j]) * 64'(s3_mag_r[c][j]);
      end
    end
  end

  // Stage 5: sum and compare against min_length squared
  logic s5_vld_r;
  logic [2:0][2:0][63:0] s5_cand_r;
  logic [2:0] s5_fail_r, s5_fail_nxt;
  tag_t s5_tag_r;

  always_comb begin
    logic [63:0] sum;
    logic [MINSQ_W-1:0] minsq;
    minsq = MINSQ_W'(min_length) * MINSQ_W'(min_length);
    for (int c = 0; c < 3; c++) begin
      sum = s4_sq_r[c][0] + s4_sq_r[c][1] + s4_sq_r[c][2];
      s5_fail_nxt[c] = s4_zero_r[c] || (sum < 64'(minsq));
    end
  end

  // Stage 6: choose the side vector and settle the status
  logic s6_vld_r;
  v64_t s6_c_r, s6_c_nxt;
  tag_t s6_tag_r, s6_tag_nxt;

  always_comb begin
    s6_tag_nxt = s5_tag_r;
    if (s5_tag_r.hint_valid) begin
      s6_c_nxt = s5_cand_r[0];
      if (s5_fail_r[0] && s5_tag_r.status == ST_OK) s6_tag_nxt.status = ST_COLLINEAR;
    end else if (!s5_fail_r[1]) begin
      s6_c_nxt = s5_cand_r[1];
    end else begin
      s6_c_nxt = s5_cand_r[2];
      if (s5_fail_r[2] && s5_tag_r.status == ST_OK) s6_tag_nxt.status = ST_COLLINEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p_r       <= cross_prod(in_tag.hint, in_f);
      s1_cu_r      <= s1_cu_nxt;
      s1_cf_r      <= s1_cf_nxt;
      s1_tag_r     <= s1_tag_nxt;
      s2_cand_r[0] <= cross_diff(s1_p_r);
      s2_cand_r[1] <= s1_cu_r;
      s2_cand_r[2] <= s1_cf_r;
      s2_tag_r     <= s1_tag_r;
      s3_cand_r    <= s2_cand_r;
      s3_mag_r     <= s3_mag_nxt;
      s3_zero_r    <= s3_zero_nxt;
      s3_tag_r     <= s2_tag_r;
      s4_cand_r    <= s3_cand_r;
      s4_sq_r      <= s4_sq_nxt;
      s4_zero_r    <= s3_zero_r;
      s4_tag_r     <= s3_tag_r;
      s5_cand_r    <= s4_cand_r;
      s5_fail_r    <= s5_fail_nxt;
      s5_tag_r     <= s4_tag_r;
      s6_c_r       <= s6_c_nxt;
      s6_tag_r     <= s6_tag_nxt;
    end
  end

  assign out_vld = s6_vld_r;
  assign out_c   = s6_c_r;
  assign out_tag = s6_tag_r;

endmodule
